@@ rtl/fmrc_pkg.sv @@
// fmrc_pkg: shared types and constants of the first-match rule classifier
// holds the rule, packet and match-config structs and register indexes
// no dependencies
package fmrc_pkg;

  localparam int MAX_RULES   = 64;
  localparam int IDX_W       = $clog2(MAX_RULES);
  localparam int COUNT_W     = 7;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [15:0] ABOVE_LIMIT = 16'd1023;

  localparam logic [COUNT_W-1:0] RULE_COUNT_RESET = 7'd0;
  localparam logic [15:0] PORT_ANY_RESET   = 16'd0;
  localparam logic [15:0] PORT_ABOVE_RESET = 16'd1023;
  localparam logic [7:0]  PROTO_ANY_RESET  = 8'd143;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_RULES);

  localparam logic [CFG_IDX_W-1:0] REG_RULE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_ANY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_ABOVE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROTO_ANY  = 2'd3;

  localparam logic KIND_WRITE    = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  typedef struct packed {
    logic [1:0]  direction;
    logic [31:0] source_address;
    logic [31:0] source_mask;
    logic [31:0] destination_address;
    logic [31:0] destination_mask;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  protocol;
    logic [1:0]  ack;
    logic        verdict;
  } rule_t;

  typedef struct packed {
    logic [1:0]  direction;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  protocol;
    logic [1:0]  ack;
  } pkt_t;

  typedef struct packed {
    logic [15:0] any_port;
    logic [15:0] port_above;
    logic [7:0]  proto_any;
  } match_cfg_t;

endpackage

@@ rtl/fmrc_rule_ram.sv @@
// fmrc_rule_ram: rule table, one write port and one read port, registered read
// depends on fmrc_pkg
module fmrc_rule_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [fmrc_pkg::IDX_W-1:0] waddr,
  input  fmrc_pkg::rule_t            wdata,
  input  logic                       re,
  input  logic [fmrc_pkg::IDX_W-1:0] raddr,
  output fmrc_pkg::rule_t            rdata
);

  fmrc_pkg::rule_t mem [fmrc_pkg::MAX_RULES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/fmrc_match.sv @@
// fmrc_match: compares one stored rule against the packet header
// depends on fmrc_pkg
module fmrc_match (
  input  fmrc_pkg::rule_t      rule,
  input  fmrc_pkg::pkt_t       pkt,
  input  fmrc_pkg::match_cfg_t cfg,
  output logic                 hit
);

  logic dir_ok, sa_ok, da_ok, sp_ok, dp_ok, proto_ok, ack_ok;

  function automatic logic port_ok(input logic [15:0] rp, input logic [15:0] pp,
                                   input fmrc_pkg::match_cfg_t c);
    logic r;
    r = (rp == c.any_port) || ((rp == c.port_above) && (pp > fmrc_pkg::ABOVE_LIMIT))
        || (rp == pp);
    return r;
  endfunction

  always_comb begin
    dir_ok   = |(rule.direction & pkt.direction);
    sa_ok    = (rule.source_address & rule.source_mask)
               == (pkt.source_address & rule.source_mask);
    da_ok    = (rule.destination_address & rule.destination_mask)
               == (pkt.destination_address & rule.destination_mask);
    sp_ok    = port_ok(rule.source_port, pkt.source_port, cfg);
    dp_ok    = port_ok(rule.destination_port, pkt.destination_port, cfg);
    proto_ok = (rule.protocol == cfg.proto_any) || (rule.protocol == pkt.protocol);
    ack_ok   = |(rule.ack & pkt.ack);
    hit      = dir_ok & sa_ok & da_ok & sp_ok & dp_ok & proto_ok & ack_ok;
  end

endmodule

@@ rtl/first_match_rule_classifier_unit.sv @@
// first_match_rule_classifier_unit: rule table with first-match packet scan
// depends on fmrc_pkg, fmrc_rule_ram, fmrc_match
// a rule write passes through ST_HOLD to out_valid; a classify scans the table in order,
//   n = min(rule_count, 64) rules, stopping at the first hit (one rule per cycle)
// one request in flight: the next is taken once ST_HOLD has handed the result to a free output
// reset: config registers to defaults, no result pending; table contents kept
module first_match_rule_classifier_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic [5:0]                     rule_index,
  input  logic [1:0]                     direction,
  input  logic [31:0]                    source_address,
  input  logic [31:0]                    source_mask,
  input  logic [31:0]                    destination_address,
  input  logic [31:0]                    destination_mask,
  input  logic [15:0]                    source_port,
  input  logic [15:0]                    destination_port,
  input  logic [7:0]                     protocol,
  input  logic [1:0]                     ack_bits,
  input  logic                           rule_action,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           verdict,
  output logic                           matched,
  output logic [5:0]                     matched_index,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fmrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fmrc_pkg::CFG_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state, state_next;

  logic [fmrc_pkg::COUNT_W-1:0] rule_count;
  fmrc_pkg::match_cfg_t         cfg;

  fmrc_pkg::pkt_t               pkt;
  logic [fmrc_pkg::COUNT_W-1:0] scan_limit;
  logic [fmrc_pkg::COUNT_W-1:0] issue_cnt, issue_cnt_next;
  logic                         check_valid, check_valid_next;
  logic [fmrc_pkg::IDX_W-1:0]   check_idx, check_idx_next;

  logic                         pend_verdict, pend_matched;
  logic [fmrc_pkg::IDX_W-1:0]   pend_index;
  logic                         set_pend;
  logic                         set_verdict, set_matched;
  logic [fmrc_pkg::IDX_W-1:0]   set_index;

  logic                         in_fire, out_free;
  logic                         ram_we, ram_re;
  fmrc_pkg::rule_t              ram_wdata, ram_rdata;
  logic                         hit, last_check;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid & in_ready;
  assign out_free  = ~out_valid | out_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count     <= fmrc_pkg::RULE_COUNT_RESET;
      cfg.any_port   <= fmrc_pkg::PORT_ANY_RESET;
      cfg.port_above <= fmrc_pkg::PORT_ABOVE_RESET;
      cfg.proto_any  <= fmrc_pkg::PROTO_ANY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fmrc_pkg::REG_RULE_COUNT: rule_count     <= cfg_data[fmrc_pkg::COUNT_W-1:0];
        fmrc_pkg::REG_PORT_ANY:   cfg.any_port   <= cfg_data;
        fmrc_pkg::REG_PORT_ABOVE: cfg.port_above <= cfg_data;
        fmrc_pkg::REG_PROTO_ANY:  cfg.proto_any  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign ram_we = in_fire & (kind == fmrc_pkg::KIND_WRITE);
  always_comb begin
    ram_wdata.direction           = direction;
    ram_wdata.source_address      = source_address;
    ram_wdata.source_mask         = source_mask;
    ram_wdata.destination_address = destination_address;
    ram_wdata.destination_mask    = destination_mask;
    ram_wdata.source_port         = source_port;
    ram_wdata.destination_port    = destination_port;
    ram_wdata.protocol            = protocol;
    ram_wdata.ack                 = ack_bits;
    ram_wdata.verdict             = rule_action;
  end

  fmrc_rule_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rule_index),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (issue_cnt[fmrc_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  fmrc_match u_match (
    .rule (ram_rdata),
    .pkt  (pkt),
    .cfg  (cfg),
    .hit  (hit)
  );

  assign last_check = ((fmrc_pkg::COUNT_W'(check_idx) + 1'b1) == scan_limit);

  always_comb begin
    state_next       = state;
    issue_cnt_next   = issue_cnt;
    check_valid_next = 1'b0;
    check_idx_next   = check_idx;
    ram_re           = 1'b0;
    set_pend         = 1'b0;
    set_verdict      = 1'b0;
    set_matched      = 1'b0;
    set_index        = '0;
    unique case (state)
      ST_IDLE: begin
        issue_cnt_next = '0;
        if (in_fire) begin
          if (kind == fmrc_pkg::KIND_WRITE) begin
            set_pend   = 1'b1;
            state_next = ST_HOLD;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (check_valid && hit) begin
          set_pend    = 1'b1;
          set_verdict = ram_rdata.verdict;
          set_matched = 1'b1;
          set_index   = check_idx;
          state_next  = ST_HOLD;
        end else if ((check_valid && last_check) || (scan_limit == '0)) begin
          set_pend   = 1'b1;
          state_next = ST_HOLD;
        end else if (issue_cnt < scan_limit) begin
          ram_re           = 1'b1;
          check_valid_next = 1'b1;
          check_idx_next   = issue_cnt[fmrc_pkg::IDX_W-1:0];
          issue_cnt_next   = issue_cnt + 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      check_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      check_valid <= check_valid_next;
      if (state == ST_HOLD && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    issue_cnt <= issue_cnt_next;
    check_idx <= check_idx_next;
    if (in_fire) begin
      pkt.direction           <= direction;
      pkt.source_address      <= source_address;
      pkt.destination_address <= destination_address;
      pkt.source_port         <= source_port;
      pkt.destination_port    <= destination_port;
      pkt.protocol            <= protocol;
      pkt.ack                 <= ack_bits;
      scan_limit <= (rule_count > fmrc_pkg::MAX_COUNT) ? fmrc_pkg::MAX_COUNT : rule_count;
    end
    if (set_pend) begin
      pend_verdict <= set_verdict;
      pend_matched <= set_matched;
      pend_index   <= set_index;
    end
    if (state == ST_HOLD && out_free) begin
      verdict       <= pend_verdict;
      matched       <= pend_matched;
      matched_index <= pend_index;
    end
  end

endmodule

@@ rtl/fmrc_checker.sv @@
// fmrc_checker: port-level checks of the classifier, bound to the top level
// depends on first_match_rule_classifier_unit
module fmrc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       verdict,
  input logic       matched,
  input logic [5:0] matched_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(matched)
      && $stable(matched_index))
    else $error("result changed while stalled");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !matched |-> !verdict && matched_index == '0)
    else $error("unmatched result carries verdict or index");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

endmodule

bind first_match_rule_classifier_unit fmrc_checker u_fmrc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .verdict       (verdict),
  .matched       (matched),
  .matched_index (matched_index)
);

@@ bench/tb_first_match_rule_classifier_unit.sv @@
// testbench for first_match_rule_classifier_unit: rule writes and packet classify requests,
// each result checked in order against a first-match predictor of the rule table
// depends on fmrc_pkg and the rtl of the classifier
module tb_first_match_rule_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            kind;
    logic [5:0]      slot;
    fmrc_pkg::rule_t rule;
  } request_t;

  typedef struct packed {
    logic        verdict;
    logic        matched;
    logic [5:0]  index;
  } outcome_t;

  class first_match_predictor;
    fmrc_pkg::rule_t rules [fmrc_pkg::MAX_RULES];
    logic [6:0]  rule_count = fmrc_pkg::RULE_COUNT_RESET;
    logic [15:0] any_port   = fmrc_pkg::PORT_ANY_RESET;
    logic [15:0] port_above = fmrc_pkg::PORT_ABOVE_RESET;
    logic [7:0]  proto_any  = fmrc_pkg::PROTO_ANY_RESET;
    outcome_t    pending [$];
    int          mismatches = 0;

    function void set_register(logic [1:0] idx, logic [15:0] data);
      case (idx)
        fmrc_pkg::REG_RULE_COUNT: rule_count = data[6:0];
        fmrc_pkg::REG_PORT_ANY:   any_port = data;
        fmrc_pkg::REG_PORT_ABOVE: port_above = data;
        fmrc_pkg::REG_PROTO_ANY:  proto_any = data[7:0];
        default: ;
      endcase
    endfunction

    function int active_rules();
      return (rule_count > fmrc_pkg::MAX_COUNT) ? fmrc_pkg::MAX_RULES : int'(rule_count);
    endfunction

    function bit port_hit(logic [15:0] rule_port, logic [15:0] pkt_port);
      return rule_port == any_port
             || (rule_port == port_above && pkt_port > fmrc_pkg::ABOVE_LIMIT)
             || rule_port == pkt_port;
    endfunction

    function bit rule_hit(fmrc_pkg::rule_t r, fmrc_pkg::rule_t p);
      return (r.direction & p.direction) != 2'b00
             && (r.source_address & r.source_mask) == (p.source_address & r.source_mask)
             && (r.destination_address & r.destination_mask)
                == (p.destination_address & r.destination_mask)
             && port_hit(r.source_port, p.source_port)
             && port_hit(r.destination_port, p.destination_port)
             && (r.protocol == proto_any || r.protocol == p.protocol)
             && (r.ack & p.ack) != 2'b00;
    endfunction

    function void note_request(request_t q);
      outcome_t o;
      o = '0;
      if (q.kind == fmrc_pkg::KIND_WRITE) begin
        rules[q.slot] = q.rule;
      end else begin
        for (int s = 0; s < active_rules(); s++) begin
          if (rule_hit(rules[s], q.rule)) begin
            o.verdict = rules[s].verdict;
            o.matched = 1'b1;
            o.index = 6'(s);
            break;
          end
        end
      end
      pending.push_back(o);
    endfunction

    function void check_verdict(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: verdict=%0d matched=%0d index=%0d",
                   got.verdict, got.matched, got.index);
        return;
      end
      want = pending.pop_front();
      if (got.verdict !== want.verdict || got.matched !== want.matched
          || got.index !== want.index) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected verdict=%0d matched=%0d index=%0d, got %0d %0d %0d",
                   want.verdict, want.matched, want.index,
                   got.verdict, got.matched, got.index);
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = 1'b0;
  logic [5:0]  rule_index = '0;
  logic [1:0]  direction = '0;
  logic [31:0] source_address = '0;
  logic [31:0] source_mask = '0;
  logic [31:0] destination_address = '0;
  logic [31:0] destination_mask = '0;
  logic [15:0] source_port = '0;
  logic [15:0] destination_port = '0;
  logic [7:0]  protocol = '0;
  logic [1:0]  ack_bits = '0;
  logic        rule_action = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        verdict;
  logic        matched;
  logic [5:0]  matched_index;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [fmrc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fmrc_pkg::CFG_W-1:0]     cfg_data = '0;

  first_match_predictor pred = new;
  int sender_gap_pct = 8;
  int receiver_gap_pct = 61;
  bit hold_start = 1'b0;
  int hold_left = 0;

  first_match_rule_classifier_unit uut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver, with one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_start) begin
        hold_start = 1'b0;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      pred.check_verdict(outcome_t'{verdict, matched, matched_index});
  end

  function automatic logic [31:0] prefix_mask();
    int len;
    len = $urandom_range(32);
    if ($urandom_range(9) == 0) return $urandom;
    return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  function automatic logic [15:0] random_rule_port();
    case ($urandom_range(4))
      0: return pred.any_port;
      1: return pred.port_above;
      2: return 16'($urandom_range(1023));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] port_for(logic [15:0] rule_port);
    int pick;
    pick = $urandom_range(3);
    if (rule_port == pred.any_port) return 16'($urandom);
    if (rule_port == pred.port_above && pick == 0) return 16'd1023;
    if (rule_port == pred.port_above && pick == 1) return 16'd1024;
    if (rule_port == pred.port_above && pick == 2) return 16'($urandom_range(65535, 1024));
    return rule_port;
  endfunction

  function automatic request_t random_rule(int slot);
    request_t q;
    q.kind = fmrc_pkg::KIND_WRITE;
    q.slot = 6'(slot);
    q.rule.direction = ($urandom_range(15) == 0) ? 2'($urandom) : 2'($urandom_range(3, 1));
    q.rule.source_address = $urandom;
    q.rule.source_mask = prefix_mask();
    q.rule.destination_address = $urandom;
    q.rule.destination_mask = prefix_mask();
    q.rule.source_port = random_rule_port();
    q.rule.destination_port = random_rule_port();
    q.rule.protocol = ($urandom_range(2) == 0) ? pred.proto_any
                    : ($urandom_range(1) == 0) ? 8'd6 : 8'($urandom);
    q.rule.ack = ($urandom_range(15) == 0) ? 2'($urandom) : 2'($urandom_range(3, 1));
    q.rule.verdict = 1'($urandom);
    return q;
  endfunction

  function automatic request_t random_packet();
    request_t q;
    fmrc_pkg::rule_t r;
    int n;
    q.kind = fmrc_pkg::KIND_CLASSIFY;
    q.slot = 6'($urandom);
    q.rule.direction = 2'($urandom);
    q.rule.source_address = $urandom;
    q.rule.source_mask = $urandom;
    q.rule.destination_address = $urandom;
    q.rule.destination_mask = $urandom;
    q.rule.source_port = 16'($urandom);
    q.rule.destination_port = 16'($urandom);
    q.rule.protocol = 8'($urandom);
    q.rule.ack = 2'($urandom);
    q.rule.verdict = 1'($urandom);
    n = pred.active_rules();
    if (n > 0 && $urandom_range(99) < 75) begin
      r = pred.rules[$urandom_range(n - 1)];
      if ((q.rule.direction & r.direction) == 2'b00)
        q.rule.direction = q.rule.direction | r.direction;
      q.rule.source_address = (r.source_address & r.source_mask)
                              | (q.rule.source_address & ~r.source_mask);
      q.rule.destination_address = (r.destination_address & r.destination_mask)
                                   | (q.rule.destination_address & ~r.destination_mask);
      q.rule.source_port = port_for(r.source_port);
      q.rule.destination_port = port_for(r.destination_port);
      if (r.protocol != pred.proto_any || $urandom_range(1) == 0)
        q.rule.protocol = r.protocol;
      if ((q.rule.ack & r.ack) == 2'b00)
        q.rule.ack = q.rule.ack | r.ack;
      // near misses
      case ($urandom_range(11))
        0: q.rule.source_address = q.rule.source_address ^ (32'h1 << $urandom_range(31));
        1: q.rule.destination_port = q.rule.destination_port + 16'd1;
        2: q.rule.protocol = q.rule.protocol + 8'd1;
        3: q.rule.ack = ~r.ack;
        4: q.rule.direction = ~r.direction;
        default: ;
      endcase
    end
    return q;
  endfunction

  function automatic request_t packet_of(logic [1:0] dir, logic [31:0] sa, logic [31:0] da,
                                         logic [15:0] sp, logic [15:0] dp, logic [7:0] pr,
                                         logic [1:0] ack);
    return request_t'{fmrc_pkg::KIND_CLASSIFY, 6'd0,
                      fmrc_pkg::rule_t'{dir, sa, 32'h0, da, 32'h0, sp, dp, pr, ack, 1'b0}};
  endfunction

  task automatic send_request(request_t q);
    @(negedge clk);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= q.kind;
    rule_index <= q.slot;
    direction <= q.rule.direction;
    source_address <= q.rule.source_address;
    source_mask <= q.rule.source_mask;
    destination_address <= q.rule.destination_address;
    destination_mask <= q.rule.destination_mask;
    source_port <= q.rule.source_port;
    destination_port <= q.rule.destination_port;
    protocol <= q.rule.protocol;
    ack_bits <= q.rule.ack;
    rule_action <= q.rule.verdict;
    do @(posedge clk); while (!in_ready);
    pred.note_request(q);
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    pred.set_register(idx, data);
  endtask

  task automatic configure(int count, int any, int above, int proto);
    write_register(fmrc_pkg::REG_RULE_COUNT, 16'(count));
    write_register(fmrc_pkg::REG_PORT_ANY, 16'(any));
    write_register(fmrc_pkg::REG_PORT_ABOVE, 16'(above));
    write_register(fmrc_pkg::REG_PROTO_ANY, 16'(proto));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pred.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int items, bit pressure);
    for (int i = 0; i < items; i++) begin
      if (pressure && i == items / 2) hold_start = 1'b1;
      if ($urandom_range(99) < 20) send_request(random_rule($urandom_range(63)));
      else send_request(random_packet());
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table at reset
    send_request(packet_of(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 2'd3));
    send_request(packet_of(2'd0, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 2'd0));
    send_request(request_t'{fmrc_pkg::KIND_WRITE, 6'd0,
      fmrc_pkg::rule_t'{2'd1, 32'h0A00_0001, 32'hFFFF_FFFF,
      32'hC0A8_0001, 32'hFFFF_FF00, 16'd1234, 16'd80, 8'd6, 2'd2, 1'b1}});
    send_request(request_t'{fmrc_pkg::KIND_WRITE, 6'd1,
      fmrc_pkg::rule_t'{2'd2, 32'h0, 32'h0, 32'h0, 32'h0,
      16'd0, 16'd1023, 8'd17, 2'd1, 1'b0}});
    send_request(request_t'{fmrc_pkg::KIND_WRITE, 6'd2,
      fmrc_pkg::rule_t'{2'd3, 32'h0, 32'h0, 32'h0, 32'h0,
      16'd1023, 16'd0, 8'd143, 2'd3, 1'b1}});
    send_request(request_t'{fmrc_pkg::KIND_WRITE, 6'd3,
      fmrc_pkg::rule_t'{2'd0, 32'h0, 32'h0, 32'h0, 32'h0,
      16'd0, 16'd0, 8'd143, 2'd3, 1'b1}});
    send_request(request_t'{fmrc_pkg::KIND_WRITE, 6'd4,
      fmrc_pkg::rule_t'{2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 2'd3, 1'b1}});
    send_request(request_t'{fmrc_pkg::KIND_WRITE, 6'd5,
      fmrc_pkg::rule_t'{2'd3, 32'h0, 32'h0, 32'h0, 32'h0,
      16'd0, 16'd0, 8'd143, 2'd3, 1'b0}});
    send_request(request_t'{fmrc_pkg::KIND_WRITE, 6'd63,
      fmrc_pkg::rule_t'{2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 2'd3, 1'b1}});
    drain();

    configure(6, 0, 1023, 143);
    send_request(packet_of(2'd1, 32'h0A00_0001, 32'hC0A8_00FE, 16'd1234, 16'd80, 8'd6, 2'd2));
    send_request(packet_of(2'd2, 32'h0A00_0001, 32'hC0A8_00FE, 16'd1234, 16'd80, 8'd6, 2'd2));
    send_request(packet_of(2'd2, 32'h1, 32'h2, 16'd5, 16'd1024, 8'd17, 2'd1));
    send_request(packet_of(2'd2, 32'h1, 32'h2, 16'd5, 16'd1000, 8'd17, 2'd1));
    send_request(packet_of(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 2'd3));
    send_request(packet_of(2'd1, 32'h0A00_0001, 32'hC0A8_00FE, 16'd1234, 16'd80, 8'd6, 2'd0));
    drain();

    // port codes equal, protocol wildcard on a real protocol
    configure(2, 80, 80, 6);
    send_request(packet_of(2'd1, 32'h0A00_0001, 32'hC0A8_0077, 16'd1234, 16'd5, 8'd99, 2'd2));
    send_request(packet_of(2'd1, 32'h0A00_0002, 32'hC0A8_0077, 16'd1234, 16'd5, 8'd99, 2'd2));
    drain();

    configure(6, 0, 1023, 143);
    for (int s = 6; s < 63; s++) send_request(random_rule(s));
    run_phase(255, 1'b0);
    configure(64, 0, 1023, 143);
    run_phase(255, 1'b1);

    sender_gap_pct = 61;
    receiver_gap_pct = 8;
    configure(127, 65535, 0, 255);
    run_phase(255, 1'b0);
    configure(32, 80, 80, 6);
    run_phase(255, 1'b0);

    sender_gap_pct = 0;
    receiver_gap_pct = 0;
    configure(65, 443, 65535, 0);
    run_phase(255, 1'b0);
    configure($urandom_range(64, 1), $urandom_range(65535), $urandom_range(65535),
              $urandom_range(255));
    run_phase(255, 1'b1);
    configure(0, 0, 1023, 143);
    run_phase(100, 1'b0);

    repeat (80) @(posedge clk);
    if (pred.mismatches == 0 && pred.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
